// ===== rtl/b64cu_pkg.sv =====
`timescale 1ns / 1ps

package b64cu_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } t_res;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < SEXTET_LOWER) begin
            c = CHAR_UPPER_A + {2'b00, v};
        end else if (v < SEXTET_DIGIT) begin
            c = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER};
        end else if (v < SEXTET_PLUS) begin
            c = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT};
        end else if (v == SEXTET_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [5:0] v;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT;
        end else if (c == CHAR_PLUS) begin
            v = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            v = SEXTET_SLASH;
        end else begin
            v = 6'd0;
        end
        return v;
    endfunction

endpackage

// ===== rtl/base64_codec_unpadded.sv =====
`timescale 1ns / 1ps

// Streaming Base64 codec, standard alphabet, no '=' padding. i_cfg_data selects
// encode (0) or decode (1); a mode write also clears the bit buffer and is taken
// only while no result is waiting. Each request is turned into its results in
// the cycle it is taken; the first result shows in the next cycle. While
// i_out_stall is low, results leave one per cycle through a two-entry result
// register, so a request that yields at most one result (every decode item,
// most encode bytes) sustains one item per cycle, while an encode request that
// yields two characters (every third byte and the final byte) holds the result
// port, and so the input, while both drain. A final decode character that
// completes no byte yields one end marker with o_empty_res high and o_data_out zero.
module base64_codec_unpadded
    import b64cu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_in,
    input  logic       i_last_in,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_out,
    output logic       o_last_out,
    output logic       o_empty_res
);

    logic       r_mode;
    logic [5:0] r_pbits;
    logic [2:0] r_pcnt;
    logic [1:0] r_ocnt;
    t_res       r_res0;
    t_res       r_res1;

    logic [5:0] n_pbits;
    logic [2:0] n_pcnt;
    logic [1:0] n_rcnt;
    t_res       n_res0;
    t_res       n_res1;

    logic       cfg_wr;
    logic       push;
    logic       pop;
    logic [5:0] sextet;

    assign o_cfg_ready = (r_ocnt == 2'd0);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign pop         = (r_ocnt != 2'd0) && !i_out_stall;
    assign o_in_stall  = i_cfg_valid || !((r_ocnt == 2'd0) || (r_ocnt == 2'd1 && pop));
    assign push        = i_in_valid && !o_in_stall;
    assign sextet      = char_to_sextet(i_data_in);

    always_comb begin
        n_res0  = '0;
        n_res1  = '0;
        n_rcnt  = 2'd1;
        n_pbits = 6'd0;
        n_pcnt  = 3'd0;
        if (r_mode == MODE_ENCODE) begin
            case (r_pcnt)
                3'd2: begin
                    n_res0.data = sextet_to_char({r_pbits[1:0], i_data_in[7:4]});
                    n_res1.data = sextet_to_char({i_data_in[3:0], 2'b00});
                    n_pbits     = {2'b00, i_data_in[3:0]};
                    n_pcnt      = 3'd4;
                    n_rcnt      = i_last_in ? 2'd2 : 2'd1;
                end
                3'd4: begin
                    n_res0.data = sextet_to_char({r_pbits[3:0], i_data_in[7:6]});
                    n_res1.data = sextet_to_char(i_data_in[5:0]);
                    n_pbits     = 6'd0;
                    n_pcnt      = 3'd0;
                    n_rcnt      = 2'd2;
                end
                default: begin
                    n_res0.data = sextet_to_char(i_data_in[7:2]);
                    n_res1.data = sextet_to_char({i_data_in[1:0], 4'b0000});
                    n_pbits     = {4'b0000, i_data_in[1:0]};
                    n_pcnt      = 3'd2;
                    n_rcnt      = i_last_in ? 2'd2 : 2'd1;
                end
            endcase
            n_res0.last = i_last_in && (n_rcnt == 2'd1);
            n_res1.last = i_last_in;
        end else begin
            case (r_pcnt)
                3'd6: begin
                    n_res0.data = {r_pbits, sextet[5:4]};
                    n_pbits     = {2'b00, sextet[3:0]};
                    n_pcnt      = 3'd4;
                end
                3'd4: begin
                    n_res0.data = {r_pbits[3:0], sextet[5:2]};
                    n_pbits     = {4'b0000, sextet[1:0]};
                    n_pcnt      = 3'd2;
                end
                3'd2: begin
                    n_res0.data = {r_pbits[1:0], sextet};
                    n_pbits     = 6'd0;
                    n_pcnt      = 3'd0;
                end
                default: begin
                    n_res0.data  = 8'd0;
                    n_res0.empty = 1'b1;
                    n_pbits      = sextet;
                    n_pcnt       = 3'd6;
                end
            endcase
            n_res0.last = i_last_in;
            n_rcnt      = (n_res0.empty && !i_last_in) ? 2'd0 : 2'd1;
        end
        if (i_last_in) begin
            n_pbits = 6'd0;
            n_pcnt  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_pbits <= 6'd0;
            r_pcnt  <= 3'd0;
            r_ocnt  <= 2'd0;
        end else begin
            if (cfg_wr) begin
                r_mode  <= i_cfg_data;
                r_pbits <= 6'd0;
                r_pcnt  <= 3'd0;
            end else if (push) begin
                r_pbits <= n_pbits;
                r_pcnt  <= n_pcnt;
            end
            if (push) begin
                r_ocnt <= n_rcnt;
            end else if (pop) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_data_out  = r_res0.data;
    assign o_last_out  = r_res0.last;
    assign o_empty_res = r_res0.empty;

endmodule

// ===== rtl/b64cu_checker.sv =====
`timescale 1ns / 1ps

module b64cu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_cfg_ready,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_out,
    input logic       o_last_out,
    input logic       o_empty_res
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_data_out) && $stable(o_last_out)
            && $stable(o_empty_res))
        else $error("stalled result changed");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_data_out == 8'd0 && o_last_out)
        else $error("end marker carries data or lacks last");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_out_valid)
        else $error("mode write offered with results pending");

    a_stall_on_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while result port blocked");

endmodule

bind base64_codec_unpadded b64cu_checker u_b64cu_checker (.*);
